FILE: src/d2rf_pkg.sv
package d2rf_pkg;

   localparam int unsigned VAL_W  = 64;
   localparam int unsigned MAG_W  = 63;
   localparam int unsigned NUM_W  = 32;
   localparam int unsigned DEN_W  = 27;
   localparam int unsigned PROD_W = 80;
   localparam int unsigned SIG_W  = 54;
   localparam int unsigned SCL_W  = 4;

   // Largest scale exponent (denominator 10^8)
   localparam logic [SCL_W-1:0] BASE_EXP = 4'd8;

   // Inverse of 5 modulo 2^32, for exact division by 5
   localparam logic [NUM_W-1:0] INV5 = 32'hCCCCCCCD;

   // Magnitude bit patterns of 2147483647.0 and 2147483648.0
   localparam logic [MAG_W-1:0] INT_TOP_MAG = 63'h41DFFFFFFFC00000;
   localparam logic [MAG_W-1:0] INT_BOT_MAG = 63'h41E0000000000000;

   // Magnitude bit patterns of 10^1 .. 10^9
   localparam logic [MAG_W-1:0] DECADE_MAG [1:9] = '{
      63'h4024000000000000, 63'h4059000000000000, 63'h408F400000000000,
      63'h40C3880000000000, 63'h40F86A0000000000, 63'h412E848000000000,
      63'h416312D000000000, 63'h4197D78400000000, 63'h41CDCD6500000000
   };

   typedef struct packed {
      logic             is_nan;
      logic             sat_pos;
      logic             sat_neg;
      logic             is_tiny;
      logic             neg;
      logic [SCL_W-1:0] scale;
   } class_type;

   // Bit length of 10^e
   function automatic logic [4:0] pow10_len(input logic [SCL_W-1:0] e);
      logic [4:0] len;
      case (e)
         4'd0:    len = 5'd1;
         4'd1:    len = 5'd4;
         4'd2:    len = 5'd7;
         4'd3:    len = 5'd10;
         4'd4:    len = 5'd14;
         4'd5:    len = 5'd17;
         4'd6:    len = 5'd20;
         4'd7:    len = 5'd24;
         default: len = 5'd27;
      endcase
      return len;
   endfunction

   // 2^twos * 5^fives
   function automatic logic [DEN_W-1:0] den_value(input logic [SCL_W-1:0] twos,
                                                   input logic [SCL_W-1:0] fives);
      logic [DEN_W-1:0] p;
      case (fives)
         4'd1:    p = 27'd5;
         4'd2:    p = 27'd25;
         4'd3:    p = 27'd125;
         4'd4:    p = 27'd625;
         4'd5:    p = 27'd3125;
         4'd6:    p = 27'd15625;
         4'd7:    p = 27'd78125;
         4'd8:    p = 27'd390625;
         default: p = 27'd1;
      endcase
      return p << twos;
   endfunction

   // Divisibility by 5: 16 is 1 mod 5, so fold hex digits
   function automatic logic mod5_zero(input logic [NUM_W-1:0] x);
      logic [6:0] s;
      logic [4:0] t;
      s = 7'd0;
      for (int i = 0; i < 8; i++) begin
         s = s + 7'(x[4*i +: 4]);
      end
      t = 5'(s[6:4]) + 5'(s[3:0]);
      if (t >= 5'd20) t = t - 5'd20;
      if (t >= 5'd10) t = t - 5'd10;
      if (t >= 5'd5)  t = t - 5'd5;
      return t == 5'd0;
   endfunction

endpackage

FILE: src/d2rf_classify.sv
module d2rf_classify (
   input  logic [d2rf_pkg::VAL_W-1:0] value_bits,
   output d2rf_pkg::class_type        cls
);
   import d2rf_pkg::*;

   logic             sign;
   logic [10:0]      expo;
   logic [51:0]      frac;
   logic [MAG_W-1:0] mag;
   logic [SCL_W-1:0] k;

   // Decode fields; positive doubles order like unsigned integers
   always_comb begin
      sign = value_bits[63];
      mag  = value_bits[62:0];
      expo = value_bits[62:52];
      frac = value_bits[51:0];
      k    = '0;
      for (int i = 1; i <= 9; i++) begin
         if (mag >= DECADE_MAG[i]) k = SCL_W'(i);
      end
      cls.is_nan  = (expo == 11'h7FF) && (frac != 52'd0);
      cls.sat_pos = !sign && (mag > INT_TOP_MAG) && !cls.is_nan;
      cls.sat_neg = sign && (mag > INT_BOT_MAG) && !cls.is_nan;
      cls.is_tiny = (expo == 11'd0);
      cls.neg     = sign;
      cls.scale   = (k > BASE_EXP) ? '0 : BASE_EXP - k;
   end

endmodule

FILE: src/double_to_reduced_fraction.sv
// Channel | Direction | Handshake            | Payload
// req     | in        | req_valid/req_stall  | req_value_bits (binary64)
// rsp     | out       | rsp_valid/rsp_stall  | rsp_numerator, rsp_denominator,
//         |           |                      | rsp_not_a_number
//
// NaN, saturated, zero and subnormal inputs skip the arithmetic and wait only for the
// output register to be free. Other inputs pass through up to 8 multiply-by-ten passes
// of the shared 80-bit adder, two rounding steps, up to 8 halving and 8 divide-by-5
// steps on the numerator register, and the load of the output register.
// req_stall is high from acceptance until the result is loaded into the output
// register; a stalled result holds and the next item may be accepted behind it.
// Reset is synchronous, active high, and empties the sequencer and output.
module double_to_reduced_fraction (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [d2rf_pkg::VAL_W-1:0]         req_value_bits,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic signed [d2rf_pkg::NUM_W-1:0]  rsp_numerator,
   output logic [d2rf_pkg::DEN_W-1:0]         rsp_denominator,
   output logic                               rsp_not_a_number
);
   import d2rf_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE, ST_SCALE, ST_ROUND, ST_INT, ST_TWO, ST_FIVE, ST_DONE
   } state_type;

   state_type         state_ff, state_in;
   logic              neg_ff, neg_in;
   logic              nan_ff, nan_in;
   logic [10:0]       exp_ff, exp_in;
   logic [SCL_W-1:0]  scale_ff, scale_in;
   logic [SCL_W-1:0]  cnt_ff, cnt_in;
   logic [SCL_W-1:0]  twos_ff, twos_in;
   logic [SCL_W-1:0]  fives_ff, fives_in;
   logic [PROD_W-1:0] prod_ff, prod_in;
   logic [SIG_W-1:0]  sig_ff, sig_in;
   logic [4:0]        drop_ff, drop_in;
   logic [NUM_W-1:0]  num_ff, num_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [NUM_W-1:0]  out_num_ff, out_num_in;
   logic [DEN_W-1:0]  out_den_ff, out_den_in;
   logic              out_nan_ff, out_nan_in;

   class_type         cls;
   logic              req_take;
   logic              out_free;

   // Per-step temporaries
   logic [4:0]        len;
   logic [6:0]        top;
   logic [4:0]        drop;
   logic [SIG_W-1:0]  kept;
   logic [DEN_W-1:0]  low, mask, half;
   logic              up;
   logic [11:0]       rsh;
   logic [5:0]        sa;

   d2rf_classify u_classify (
      .value_bits (req_value_bits),
      .cls        (cls)
   );

   assign req_stall = (state_ff != ST_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   // Sequencer and shared datapath
   always_comb begin
      state_in     = state_ff;
      neg_in       = neg_ff;
      nan_in       = nan_ff;
      exp_in       = exp_ff;
      scale_in     = scale_ff;
      cnt_in       = cnt_ff;
      twos_in      = twos_ff;
      fives_in     = fives_ff;
      prod_in      = prod_ff;
      sig_in       = sig_ff;
      drop_in      = drop_ff;
      num_in       = num_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      out_num_in   = out_num_ff;
      out_den_in   = out_den_ff;
      out_nan_in   = out_nan_ff;

      len  = pow10_len(scale_ff);
      top  = 7'd52 + 7'(len);
      drop = prod_ff[top] ? len : len - 5'd1;
      kept = SIG_W'(prod_ff >> drop);
      mask = (DEN_W'(1) << drop) - DEN_W'(1);
      low  = prod_ff[DEN_W-1:0] & mask;
      half = (drop == 5'd0) ? '0 : DEN_W'(1) << (drop - 5'd1);
      up   = (drop != 5'd0) && ((low > half) || ((low == half) && kept[0]));
      rsh  = 12'd1075 - 12'(exp_ff) - 12'(drop_ff);
      sa   = rsh[5:0];

      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               neg_in   = cls.neg;
               nan_in   = cls.is_nan;
               exp_in   = req_value_bits[62:52];
               scale_in = cls.scale;
               cnt_in   = cls.scale;
               twos_in  = cls.scale;
               fives_in = cls.scale;
               prod_in  = {27'd0, 1'b1, req_value_bits[51:0]};
               num_in   = '0;
               state_in = ST_SCALE;
               if (cls.is_nan || cls.sat_pos || cls.sat_neg || cls.is_tiny) begin
                  twos_in  = '0;
                  fives_in = '0;
                  neg_in   = 1'b0;
                  state_in = ST_DONE;
                  if (cls.sat_pos) num_in = 32'h7FFFFFFF;
                  if (cls.sat_neg) num_in = 32'h80000000;
               end
            end
         end
         ST_SCALE: begin
            // multiply by ten: x*8 + x*2
            if (cnt_ff != '0) begin
               prod_in = (prod_ff << 3) + (prod_ff << 1);
               cnt_in  = cnt_ff - 4'd1;
            end else begin
               state_in = ST_ROUND;
            end
         end
         ST_ROUND: begin
            // round the product to 53 bits, nearest even
            sig_in   = kept + SIG_W'(up);
            drop_in  = drop;
            state_in = ST_INT;
         end
         ST_INT: begin
            // round to integer, half away from zero
            if (rsh > 12'd54) begin
               num_in = '0;
            end else begin
               num_in = NUM_W'((sig_ff >> sa) + SIG_W'(sig_ff[sa - 6'd1]));
            end
            state_in = ST_TWO;
         end
         ST_TWO: begin
            if (twos_ff != '0 && !num_ff[0]) begin
               num_in  = num_ff >> 1;
               twos_in = twos_ff - 4'd1;
            end else begin
               state_in = ST_FIVE;
            end
         end
         ST_FIVE: begin
            if (fives_ff != '0 && mod5_zero(num_ff)) begin
               num_in   = NUM_W'(num_ff * INV5);
               fives_in = fives_ff - 4'd1;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            // load the output register once it is free
            if (out_free) begin
               rsp_valid_in = 1'b1;
               out_num_in   = neg_ff ? (NUM_W'(0) - num_ff) : num_ff;
               out_den_in   = den_value(twos_ff, fives_ff);
               out_nan_in   = nan_ff;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Hold state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      neg_ff     <= neg_in;
      nan_ff     <= nan_in;
      exp_ff     <= exp_in;
      scale_ff   <= scale_in;
      cnt_ff     <= cnt_in;
      twos_ff    <= twos_in;
      fives_ff   <= fives_in;
      prod_ff    <= prod_in;
      sig_ff     <= sig_in;
      drop_ff    <= drop_in;
      num_ff     <= num_in;
      out_num_ff <= out_num_in;
      out_den_ff <= out_den_in;
      out_nan_ff <= out_nan_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_numerator    = signed'(out_num_ff);
   assign rsp_denominator  = out_den_ff;
   assign rsp_not_a_number = out_nan_ff;

   // NaN results are always 0/1
   a_nan_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_not_a_number |-> rsp_numerator == 0 && rsp_denominator == 27'd1)
      else $error("NaN result not 0/1");

   // Denominator is never zero
   a_den_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_denominator != '0)
      else $error("zero denominator");

   // Sequencer leaves idle only on a transfer
   a_idle_hold: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_IDLE && !req_take |=> state_ff == ST_IDLE)
      else $error("sequencer started without a transfer");

   // Positive saturation always has denominator 1
   a_sat_den: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_numerator == 32'sh7FFFFFFF |-> rsp_denominator == 27'd1)
      else $error("saturated numerator with denominator above 1");

endmodule
